// File: rtl/serial_frame_receiver_xor_check_assert.svh
// assertion macros shared by the serial frame receiver modules
`ifndef SERIAL_FRAME_RECEIVER_XOR_CHECK_ASSERT_SVH
`define SERIAL_FRAME_RECEIVER_XOR_CHECK_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SFRX_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("sfrx assertion failed");
`define SFRX_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("sfrx assertion failed");
`else
`define SFRX_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define SFRX_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/sfrx_pkg.sv
// types, constants and helpers of the serial frame receiver
package sfrx_pkg;

    localparam int BUFFER_BYTES = 1024;
    localparam int BUF_AW       = $clog2(BUFFER_BYTES);
    localparam int CNT_W        = $clog2(BUFFER_BYTES + 1);
    localparam int MEM_DEPTH    = 2 * BUFFER_BYTES;
    localparam int MEM_AW       = BUF_AW + 1;
    localparam int LEN_W        = 16;
    localparam int LEN_EXT_W    = LEN_W + 1;
    localparam int WLEN_W       = 10;
    localparam int ADDR_W       = 32;
    localparam int ACK_BEATS    = 9;
    localparam int BEAT_W       = $clog2(ACK_BEATS);
    localparam int OUT_W        = 56;

    // frame layout offsets
    localparam int POS_HEAD0      = 0;
    localparam int POS_HEAD1      = 1;
    localparam int POS_CMD        = 2;
    localparam int POS_LEN_HI     = 3;
    localparam int POS_LEN_LO     = 4;
    localparam int POS_PAYLOAD    = 5;
    localparam int POS_ADDR_LAST  = 8;
    localparam int FRAME_OVERHEAD = 8;

    localparam logic [7:0] SYNC_A         = 8'hC5;
    localparam logic [7:0] SYNC_B         = 8'h5C;
    localparam logic [7:0] ACK_LEN_HI     = 8'h00;
    localparam logic [7:0] ACK_LEN_LO     = 8'h01;
    localparam logic [7:0] IDLE_LIMIT_RST = 8'd10;

    localparam logic [7:0] CMD_DATA  = 8'h00;
    localparam logic [7:0] CMD_START = 8'h01;
    localparam logic [7:0] CMD_END   = 8'h02;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_HEAD   = 3'd1,
        ST_CHECK  = 3'd2,
        ST_TAIL   = 3'd3,
        ST_LENGTH = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CK_IDLE,
        CK_SCAN,
        CK_TAIL
    } t_chk_state;

    typedef struct packed {
        logic             bank;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_chk_req;

    typedef struct packed {
        t_status           status;
        logic [7:0]        cmd;
        logic [LEN_W-1:0]  len;
        logic [ADDR_W-1:0] addr;
    } t_chk_res;

    function automatic logic [7:0] ack_byte(input logic [BEAT_W-1:0] beat,
                                            input logic [7:0] cmd,
                                            input t_status status);
        logic [7:0] st8;
        st8 = {5'b0, status};
        case (beat)
            BEAT_W'(0): ack_byte = SYNC_A;
            BEAT_W'(1): ack_byte = SYNC_B;
            BEAT_W'(2): ack_byte = cmd;
            BEAT_W'(3): ack_byte = ACK_LEN_HI;
            BEAT_W'(4): ack_byte = ACK_LEN_LO;
            BEAT_W'(5): ack_byte = st8;
            BEAT_W'(6): ack_byte = cmd ^ ACK_LEN_HI ^ ACK_LEN_LO ^ st8;
            BEAT_W'(7): ack_byte = SYNC_B;
            default:    ack_byte = SYNC_A;
        endcase
    endfunction

endpackage

// File: rtl/sfrx_ram.sv
// generic simple dual-port ram with registered read
module sfrx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/sfrx_check.sv
// frame checker: scans one buffer bank and produces status and decoded fields
`include "serial_frame_receiver_xor_check_assert.svh"
module sfrx_check (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  sfrx_pkg::t_chk_req        i_req,
    output logic                      o_busy,
    output logic                      o_rd_en,
    output logic [sfrx_pkg::MEM_AW-1:0] o_rd_addr,
    input  logic [7:0]                i_rd_data,
    output logic                      o_done,
    output sfrx_pkg::t_chk_res        o_res
);
    import sfrx_pkg::*;

    t_chk_state           r_state;
    t_chk_state           n_state;
    t_chk_req             r_req;
    logic [CNT_W-1:0]     r_p;
    logic [BUF_AW-1:0]    r_q;
    logic                 r_rd_valid;
    logic                 r_len_known;
    logic [7:0]           r_b0;
    logic [7:0]           r_b1;
    logic [7:0]           r_cmd;
    logic [7:0]           r_lhi;
    logic [7:0]           r_llo;
    logic [7:0]           r_chk;
    logic [7:0]           r_t0;
    logic [7:0]           r_t1;
    logic [7:0]           r_xor;
    logic [ADDR_W-1:0]    r_addr;

    logic [LEN_EXT_W-1:0] len_ext;
    logic [LEN_EXT_W-1:0] len_end;
    logic [LEN_EXT_W-1:0] cnt_ext;
    logic [LEN_EXT_W-1:0] p_ext;
    logic [LEN_EXT_W-1:0] q_ext;
    logic                 rd_issue;
    t_status              status;

    assign len_ext = LEN_EXT_W'({r_lhi, r_llo});
    assign len_end = len_ext + LEN_EXT_W'(FRAME_OVERHEAD);
    assign cnt_ext = LEN_EXT_W'(r_req.count);
    assign p_ext   = LEN_EXT_W'(r_p);
    assign q_ext   = LEN_EXT_W'(r_q);

    // stop at the end of the stored bytes, or past the tail once all address bytes are in
    assign rd_issue = (r_state == CK_SCAN) && (r_p < r_req.count)
                      && !(r_len_known && (p_ext >= len_end)
                           && (p_ext > LEN_EXT_W'(POS_ADDR_LAST)));

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CK_IDLE: begin
                if (i_start) begin
                    n_state = CK_SCAN;
                end
            end
            CK_SCAN: begin
                if (!rd_issue) begin
                    n_state = CK_TAIL;
                end
            end
            CK_TAIL: begin
                n_state = CK_IDLE;
            end
            default: n_state = CK_IDLE;
        endcase
    end

    always_comb begin
        o_busy    = (r_state != CK_IDLE);
        o_done    = (r_state == CK_TAIL);
        o_rd_en   = rd_issue;
        o_rd_addr = {r_req.bank, r_p[BUF_AW-1:0]};
    end

    always_comb begin
        if (r_req.overflow || (r_req.count < CNT_W'(POS_CMD))) begin
            status = ST_LENGTH;
        end else if ((r_b0 != SYNC_A) || (r_b1 != SYNC_B)) begin
            status = ST_HEAD;
        end else if (r_req.count < CNT_W'(POS_PAYLOAD)) begin
            status = ST_LENGTH;
        end else if (len_end > cnt_ext) begin
            status = ST_LENGTH;
        end else if (r_xor != r_chk) begin
            status = ST_CHECK;
        end else if ((r_t0 != SYNC_B) || (r_t1 != SYNC_A)) begin
            status = ST_TAIL;
        end else begin
            status = ST_OK;
        end
    end

    assign o_res = '{status: status, cmd: r_cmd, len: {r_lhi, r_llo}, addr: r_addr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= CK_IDLE;
            r_rd_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= rd_issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == CK_IDLE) && i_start) begin
            r_req       <= i_req;
            r_p         <= '0;
            r_len_known <= 1'b0;
            r_b0        <= '0;
            r_b1        <= '0;
            r_cmd       <= '0;
            r_lhi       <= '0;
            r_llo       <= '0;
            r_chk       <= '0;
            r_t0        <= '0;
            r_t1        <= '0;
            r_xor       <= '0;
            r_addr      <= '0;
        end else begin
            if (rd_issue) begin
                r_p <= r_p + CNT_W'(1);
                r_q <= r_p[BUF_AW-1:0];
            end
            if (r_rd_valid) begin
                if (q_ext == LEN_EXT_W'(POS_HEAD0)) begin
                    r_b0 <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_HEAD1)) begin
                    r_b1 <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_CMD)) begin
                    r_cmd <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_LEN_HI)) begin
                    r_lhi <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_LEN_LO)) begin
                    r_llo       <= i_rd_data;
                    r_len_known <= 1'b1;
                end
                if (q_ext == LEN_EXT_W'(POS_PAYLOAD)) begin
                    r_addr[31:24] <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_PAYLOAD + 1)) begin
                    r_addr[23:16] <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_PAYLOAD + 2)) begin
                    r_addr[15:8] <= i_rd_data;
                end
                if (q_ext == LEN_EXT_W'(POS_ADDR_LAST)) begin
                    r_addr[7:0] <= i_rd_data;
                end
                // check covers command through the last payload byte
                if ((q_ext >= LEN_EXT_W'(POS_CMD)) && ((q_ext < LEN_EXT_W'(POS_PAYLOAD))
                    || (q_ext < len_ext + LEN_EXT_W'(POS_PAYLOAD)))) begin
                    r_xor <= r_xor ^ i_rd_data;
                end
                if (q_ext >= LEN_EXT_W'(POS_PAYLOAD)) begin
                    if (q_ext == len_ext + LEN_EXT_W'(POS_PAYLOAD)) begin
                        r_chk <= i_rd_data;
                    end
                    if (q_ext == len_ext + LEN_EXT_W'(POS_PAYLOAD + 1)) begin
                        r_t0 <= i_rd_data;
                    end
                    if (q_ext == len_ext + LEN_EXT_W'(POS_PAYLOAD + 2)) begin
                        r_t1 <= i_rd_data;
                    end
                end
            end
        end
    end

    `SFRX_ASSERT_IMP(a_read_in_frame, i_clk, i_rst_n, r_rd_valid, CNT_W'(r_q) < r_req.count)
    `SFRX_ASSERT_IMP(a_drained_at_verdict, i_clk, i_rst_n, r_state == CK_TAIL, !r_rd_valid)
    `SFRX_ASSERT_NEXT(a_start_scans, i_clk, i_rst_n, (r_state == CK_IDLE) && i_start, r_state == CK_SCAN)

endmodule

// File: rtl/serial_frame_receiver_xor_check.sv
// top level: byte buffering, idle timeout, command execution and acknowledge output
//
// Input stream: one transfer per received serial byte (tuser 0, byte in tdata)
// or per one millisecond tick (tuser 1, tdata ignored). Bytes are written into
// one bank of a two-bank buffer ram; a tick that takes the idle count past
// idle_limit closes the frame, hands that bank to the checker and switches the
// writer to the other bank, so the next frame is taken in at once.
// The checker reads the closed bank one byte a cycle, N reads where N is the
// stored byte count, cut short after the tail but never before the ninth byte.
// The acknowledge starts once the checker is done; its nine bytes then leave at one
// per cycle while the output side is ready. Bytes and non-closing ticks are taken
// every cycle. A closing tick is held off (tready low) while the previous frame is
// still being checked or acknowledged; a stall on the output side therefore also
// holds such ticks. idle_limit is to be written through i_cfg_we / i_cfg_wdata
// only while the block idles; the block does not enforce this. Reset (synchronous,
// active low) empties the buffer, clears the transfer state, base address and
// stored total, and sets idle_limit to 10.
`include "serial_frame_receiver_xor_check_assert.svh"
module serial_frame_receiver_xor_check (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [7:0]                  i_cfg_wdata,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [7:0]                  s_axis_tdata,  // rx_byte
    input  logic                        s_axis_tuser,  // mode
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // ack_byte, frame_status, write_valid, write_address, write_length,
    // transfer_active, one zero pad bit
    output logic [sfrx_pkg::OUT_W-1:0]  m_axis_tdata,
    output logic                        m_axis_tlast   // ack_last
);
    import sfrx_pkg::*;

    logic [7:0]         r_idle_limit;
    logic [CNT_W-1:0]   r_count;
    logic               r_ovf;
    logic [7:0]         r_idle;
    logic               r_receiving;
    logic               r_bank;
    logic [ADDR_W-1:0]  r_total;
    logic [ADDR_W-1:0]  r_base;
    logic               r_active;
    logic               r_emit;
    logic [BEAT_W-1:0]  r_beat;
    logic               r_out_valid;
    logic [OUT_W-1:0]   r_out_data;
    logic               r_out_last;
    logic [7:0]         r_ack_cmd;
    t_status            r_ack_status;
    logic               r_ack_wv;
    logic [ADDR_W-1:0]  r_ack_wa;
    logic [WLEN_W-1:0]  r_ack_wl;
    logic               r_ack_active;

    logic [ADDR_W-1:0]  n_total;
    logic [ADDR_W-1:0]  n_base;
    logic               n_active;
    logic               n_wv;
    logic [ADDR_W-1:0]  n_wa;
    logic [WLEN_W-1:0]  n_wl;

    logic               accept;
    logic               close_cond;
    logic               busy;
    logic               chk_start;
    logic               chk_busy;
    logic               chk_done;
    t_chk_req           chk_req;
    t_chk_res           chk_res;
    logic               wr_en;
    logic               rd_en;
    logic [MEM_AW-1:0]  rd_addr;
    logic [7:0]         rd_data;
    logic               out_load;

    assign close_cond = s_axis_tuser && r_receiving
                        && (({1'b0, r_idle} + 9'd1) > {1'b0, r_idle_limit});
    assign busy       = chk_busy || r_emit;
    assign s_axis_tready = !(close_cond && busy);
    assign accept     = s_axis_tvalid && s_axis_tready;
    assign chk_start  = accept && close_cond;
    assign wr_en      = accept && !s_axis_tuser && (r_count < CNT_W'(BUFFER_BYTES));
    assign chk_req    = '{bank: r_bank, count: r_count, overflow: r_ovf};

    sfrx_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr ({r_bank, r_count[BUF_AW-1:0]}),
        .i_wdata (s_axis_tdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (rd_data)
    );

    sfrx_check u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (chk_start),
        .i_req     (chk_req),
        .o_busy    (chk_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .o_done    (chk_done),
        .o_res     (chk_res)
    );

    // command execution on the checker verdict
    always_comb begin
        n_total  = r_total;
        n_base   = r_base;
        n_active = r_active;
        n_wv     = 1'b0;
        n_wa     = '0;
        n_wl     = '0;
        if (chk_res.status == ST_OK) begin
            case (chk_res.cmd)
                CMD_DATA: begin
                    n_wv    = 1'b1;
                    n_wa    = r_base + r_total;
                    n_wl    = chk_res.len[WLEN_W-1:0];
                    n_total = r_total + ADDR_W'(chk_res.len);
                end
                CMD_START: begin
                    n_active = 1'b1;
                    n_total  = '0;
                    n_base   = chk_res.addr;
                end
                CMD_END: begin
                    n_active = 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_limit <= IDLE_LIMIT_RST;
        end else if (i_cfg_we) begin
            r_idle_limit <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_idle      <= '0;
            r_receiving <= 1'b0;
            r_bank      <= 1'b0;
        end else if (accept) begin
            if (!s_axis_tuser) begin
                if (r_count < CNT_W'(BUFFER_BYTES)) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
                r_receiving <= 1'b1;
                r_idle      <= '0;
            end else if (close_cond) begin
                r_count     <= '0;
                r_ovf       <= 1'b0;
                r_idle      <= '0;
                r_receiving <= 1'b0;
                r_bank      <= !r_bank;
            end else if (r_receiving) begin
                r_idle <= r_idle + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total  <= '0;
            r_base   <= '0;
            r_active <= 1'b0;
        end else if (chk_done) begin
            r_total  <= n_total;
            r_base   <= n_base;
            r_active <= n_active;
        end
    end

    always_ff @(posedge i_clk) begin
        if (chk_done) begin
            r_ack_cmd    <= chk_res.cmd;
            r_ack_status <= chk_res.status;
            r_ack_wv     <= n_wv;
            r_ack_wa     <= n_wa;
            r_ack_wl     <= n_wl;
            r_ack_active <= n_active;
        end
    end

    assign out_load = r_emit && (!r_out_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_emit      <= 1'b0;
            r_beat      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (chk_done) begin
                r_emit <= 1'b1;
                r_beat <= '0;
            end else if (out_load) begin
                if (r_beat == BEAT_W'(ACK_BEATS - 1)) begin
                    r_emit <= 1'b0;
                    r_beat <= '0;
                end else begin
                    r_beat <= r_beat + BEAT_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_data <= {1'b0, r_ack_active, r_ack_wl, r_ack_wa, r_ack_wv, r_ack_status,
                           ack_byte(r_beat, r_ack_cmd, r_ack_status)};
            r_out_last <= (r_beat == BEAT_W'(ACK_BEATS - 1));
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    `SFRX_ASSERT_IMP(a_start_when_free, i_clk, i_rst_n, chk_start, !r_emit && !chk_busy)
    `SFRX_ASSERT_NEXT(a_done_emits, i_clk, i_rst_n, chk_done, r_emit && (r_beat == '0))
    `SFRX_ASSERT_IMP(a_last_is_sync, i_clk, i_rst_n, r_out_valid && r_out_last, r_out_data[7:0] == SYNC_A)

endmodule
